// ===== src/swdf_pkg.sv =====
`timescale 1ns / 1ps

package swdf_pkg;

  // Fixed field widths of the byte stream and the result beat.
  localparam int BYTE_W       = 8;
  localparam int KIND_W       = 2;
  localparam int REPLY_W      = 3;
  localparam int WORD_COUNT_W = 16;
  localparam int ACC_W        = 28;
  localparam int NCAND        = 4;
  localparam int CAND_MAX     = 6;
  localparam int POS_W        = 3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

  // Reply types reported at sentence end.
  localparam logic [REPLY_W-1:0] RT_OTHER = 3'd0;
  localparam logic [REPLY_W-1:0] RT_DONE  = 3'd1;
  localparam logic [REPLY_W-1:0] RT_RE    = 3'd2;
  localparam logic [REPLY_W-1:0] RT_TRAP  = 3'd3;
  localparam logic [REPLY_W-1:0] RT_FATAL = 3'd4;

  // Length prefix lead byte markers.
  localparam logic [BYTE_W-1:0] LEAD_BAD = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_4B  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_3B  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_2B  = 8'h80;

  // Candidate first words: "!done", "!re", "!trap", "!fatal".
  localparam logic [BYTE_W-1:0] CAND_TEXT [NCAND][CAND_MAX] = '{
    '{8'h21, 8'h64, 8'h6F, 8'h6E, 8'h65, 8'h00},
    '{8'h21, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h21, 8'h74, 8'h72, 8'h61, 8'h70, 8'h00},
    '{8'h21, 8'h66, 8'h61, 8'h74, 8'h61, 8'h6C}
  };
  localparam logic [POS_W-1:0] CAND_LEN [NCAND] = '{3'd5, 3'd3, 3'd5, 3'd6};

  // First-word match state: one live flag per candidate and the byte position.
  typedef struct packed {
    logic [NCAND-1:0] flags;
    logic [POS_W-1:0] pos;
  } match_t;

  localparam match_t MATCH_INIT = '{flags: '1, pos: '0};

endpackage

// ===== src/api_sentence_word_deframer_core.sv =====
`timescale 1ns / 1ps
// Length-prefixed word deframer.
// Input channel: one received byte per beat on in_rx_byte (in_valid/in_ready).
// Output channel: one result beat per payload byte, per sentence end and per
// bad length lead byte; prefix bytes that do not end a sentence give no beat.
// Payload beats carry the byte with word start/end flags. A sentence end beat
// carries the word count (saturating) and the reply type from an exact match
// of the first word against "!done", "!re", "!trap" and "!fatal".
// Throughput: one byte per cycle while the receiver does not stall. A result
// appears on out_valid in the cycle after its byte is accepted. All decode
// work is a single combinational pass from the parser state registers into
// the result register. in_ready is high while the result register is empty
// or being drained in the same cycle, so when the receiver stalls, one result
// is held and the input stalls with it; nothing is dropped.
// Reset (rst_n low, synchronous) empties the result register and returns the
// parser to the start of a sentence, awaiting a length lead byte.
// LENGTH_BITS caps word lengths (longer ones saturate); COUNT_BITS sizes the
// word counter.
module api_sentence_word_deframer_core
  import swdf_pkg::*;
#(
  parameter int LENGTH_BITS = 28,
  parameter int COUNT_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BYTE_W-1:0]       in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KIND_W-1:0]       out_kind,
  output logic [BYTE_W-1:0]       out_data_byte,
  output logic                    out_word_start,
  output logic                    out_word_end,
  output logic [REPLY_W-1:0]      out_reply_type,
  output logic [WORD_COUNT_W-1:0] out_word_count
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PREFIX  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [ACC_W-1:0] MaxLen = ACC_W'((64'd1 << LENGTH_BITS) - 64'd1);

  // Parser state.
  logic [1:0]             phase_r, phase_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [1:0]             prefix_left_r, prefix_left_nxt;
  logic [LENGTH_BITS-1:0] payload_left_r, payload_left_nxt;
  logic                   at_word_start_r, at_word_start_nxt;
  logic                   in_first_word_r, in_first_word_nxt;
  match_t                 match_r, match_nxt;
  logic [COUNT_BITS-1:0]  words_r, words_nxt;

  // Result register.
  logic                    out_valid_r;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [BYTE_W-1:0]       data_r, data_nxt;
  logic                    ws_r, ws_nxt;
  logic                    we_r, we_nxt;
  logic [REPLY_W-1:0]      rt_r, rt_nxt;
  logic [WORD_COUNT_W-1:0] cnt_r, cnt_nxt;

  logic              in_fire;
  logic              emit_c;
  logic              fin_c;
  logic [ACC_W-1:0]  fin_acc;
  logic [ACC_W-1:0]  fin_len;
  logic [ACC_W-1:0]  acc_shift;
  logic              last_c;
  match_t            match_step;
  logic [REPLY_W-1:0] reply_c;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  swdf_matcher u_matcher (
    .cur_i       (match_r),
    .byte_i      (in_rx_byte),
    .word_last_i (last_c),
    .nxt_o       (match_step),
    .reply_o     (reply_c)
  );

  assign last_c    = (payload_left_r <= LENGTH_BITS'(1));
  assign acc_shift = {acc_r[ACC_W-BYTE_W-1:0], in_rx_byte};

  // Next parser state and result for the byte on the input.
  always_comb begin
    phase_nxt         = phase_r;
    acc_nxt           = acc_r;
    prefix_left_nxt   = prefix_left_r;
    payload_left_nxt  = payload_left_r;
    at_word_start_nxt = at_word_start_r;
    in_first_word_nxt = in_first_word_r;
    match_nxt         = match_r;
    words_nxt         = words_r;
    emit_c            = 1'b0;
    kind_nxt          = KIND_PAYLOAD;
    data_nxt          = '0;
    ws_nxt            = 1'b0;
    we_nxt            = 1'b0;
    rt_nxt            = RT_OTHER;
    cnt_nxt           = '0;
    fin_c             = 1'b0;
    fin_acc           = '0;
    fin_len           = '0;

    case (phase_r)
      PH_PAYLOAD: begin
        emit_c            = 1'b1;
        data_nxt          = in_rx_byte;
        ws_nxt            = at_word_start_r;
        we_nxt            = last_c;
        at_word_start_nxt = 1'b0;
        if (in_first_word_r) begin
          match_nxt = match_step;
          if (last_c) begin
            in_first_word_nxt = 1'b0;
          end
        end
        if (last_c) begin
          if (words_r != '1) begin
            words_nxt = words_r + COUNT_BITS'(1);
          end
          payload_left_nxt = '0;
          phase_nxt        = PH_IDLE;
        end else begin
          payload_left_nxt = payload_left_r - LENGTH_BITS'(1);
        end
      end
      PH_PREFIX: begin
        if (prefix_left_r > 2'd1) begin
          acc_nxt         = acc_shift;
          prefix_left_nxt = prefix_left_r - 2'd1;
        end else begin
          fin_c   = 1'b1;
          fin_acc = acc_shift;
        end
      end
      PH_IDLE: begin
        if (in_rx_byte >= LEAD_BAD) begin
          emit_c   = 1'b1;
          kind_nxt = KIND_BAD;
        end else if ((in_rx_byte & LEAD_4B) == LEAD_4B) begin
          acc_nxt         = ACC_W'(in_rx_byte[3:0]);
          prefix_left_nxt = 2'd3;
          phase_nxt       = PH_PREFIX;
        end else if ((in_rx_byte & LEAD_3B) == LEAD_3B) begin
          acc_nxt         = ACC_W'(in_rx_byte[4:0]);
          prefix_left_nxt = 2'd2;
          phase_nxt       = PH_PREFIX;
        end else if ((in_rx_byte & LEAD_2B) == LEAD_2B) begin
          acc_nxt         = ACC_W'(in_rx_byte[5:0]);
          prefix_left_nxt = 2'd1;
          phase_nxt       = PH_PREFIX;
        end else begin
          fin_c   = 1'b1;
          fin_acc = ACC_W'(in_rx_byte[6:0]);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // A finished prefix either ends the sentence or opens a word.
    if (fin_c) begin
      fin_len         = (fin_acc > MaxLen) ? MaxLen : fin_acc;
      acc_nxt         = '0;
      prefix_left_nxt = '0;
      if (fin_len == '0) begin
        emit_c            = 1'b1;
        kind_nxt          = KIND_END;
        rt_nxt            = in_first_word_r ? RT_OTHER : reply_c;
        cnt_nxt           = WORD_COUNT_W'(words_r);
        phase_nxt         = PH_IDLE;
        at_word_start_nxt = 1'b1;
        in_first_word_nxt = 1'b1;
        match_nxt         = MATCH_INIT;
        words_nxt         = '0;
      end else begin
        payload_left_nxt  = fin_len[LENGTH_BITS-1:0];
        at_word_start_nxt = 1'b1;
        phase_nxt         = PH_PAYLOAD;
      end
    end
  end

  // Parser state registers, advanced on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      acc_r           <= '0;
      prefix_left_r   <= '0;
      payload_left_r  <= '0;
      at_word_start_r <= 1'b1;
      in_first_word_r <= 1'b1;
      match_r         <= MATCH_INIT;
      words_r         <= '0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      acc_r           <= acc_nxt;
      prefix_left_r   <= prefix_left_nxt;
      payload_left_r  <= payload_left_nxt;
      at_word_start_r <= at_word_start_nxt;
      in_first_word_r <= in_first_word_nxt;
      match_r         <= match_nxt;
      words_r         <= words_nxt;
    end
  end

  // Result register valid: loaded on accept, emptied when drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit_c;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire && emit_c) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      ws_r   <= ws_nxt;
      we_r   <= we_nxt;
      rt_r   <= rt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_data_byte  = data_r;
  assign out_word_start = ws_r;
  assign out_word_end   = we_r;
  assign out_reply_type = rt_r;
  assign out_word_count = cnt_r;

endmodule

// ===== src/swdf_matcher.sv =====
`timescale 1ns / 1ps

module swdf_matcher
  import swdf_pkg::*;
(
  input  match_t              cur_i,
  input  logic [BYTE_W-1:0]   byte_i,
  input  logic                word_last_i,
  output match_t              nxt_o,
  output logic [REPLY_W-1:0]  reply_o
);

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] idx;
  logic [NCAND-1:0] flags_c;

  // Compare this byte against each candidate; at word end the length must match too.
  always_comb begin
    pos_inc = (cur_i.pos == '1) ? cur_i.pos : cur_i.pos + POS_W'(1);
    idx     = (cur_i.pos < POS_W'(CAND_MAX)) ? cur_i.pos : '0;
    for (int k = 0; k < NCAND; k++) begin
      flags_c[k] = cur_i.flags[k] && (cur_i.pos < CAND_LEN[k]) &&
                   (CAND_TEXT[k][idx] == byte_i);
      if (word_last_i && (CAND_LEN[k] != pos_inc)) begin
        flags_c[k] = 1'b0;
      end
    end
    nxt_o.flags = flags_c;
    nxt_o.pos   = pos_inc;
  end

  // The first surviving candidate names the reply.
  always_comb begin
    if (cur_i.flags[0]) begin
      reply_o = RT_DONE;
    end else if (cur_i.flags[1]) begin
      reply_o = RT_RE;
    end else if (cur_i.flags[2]) begin
      reply_o = RT_TRAP;
    end else if (cur_i.flags[3]) begin
      reply_o = RT_FATAL;
    end else begin
      reply_o = RT_OTHER;
    end
  end

endmodule

// ===== src/swdf_checker.sv =====
`timescale 1ns / 1ps

module swdf_checker
  import swdf_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [KIND_W-1:0]       out_kind,
  input logic [BYTE_W-1:0]       out_data_byte,
  input logic                    out_word_start,
  input logic                    out_word_end,
  input logic [REPLY_W-1:0]      out_reply_type,
  input logic [WORD_COUNT_W-1:0] out_word_count
);

  // A stalled result beat holds its kind, data byte, reply type and word count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_reply_type) && $stable(out_word_count))
    else $error("result beat changed while stalled");

  // The input is never refused while the result register is free.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Only payload beats carry a byte and word flags.
  a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |->
      out_data_byte == '0 && !out_word_start && !out_word_end)
    else $error("non-payload beat carries payload fields");

  // Only sentence end beats carry reply type and count, and the kind is known.
  a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_END |->
      out_reply_type == RT_OTHER && out_word_count == '0 &&
      (out_kind == KIND_PAYLOAD || out_kind == KIND_BAD))
    else $error("non-end beat carries sentence fields");

  // Reply type stays within its codes.
  a_reply_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reply_type <= RT_FATAL)
    else $error("reply type out of range");

endmodule

bind api_sentence_word_deframer_core swdf_checker u_swdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_data_byte  (out_data_byte),
  .out_word_start (out_word_start),
  .out_word_end   (out_word_end),
  .out_reply_type (out_reply_type),
  .out_word_count (out_word_count)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import swdf_pkg::*;

  localparam int LEN_BITS = 28;
  localparam int CNT_BITS = 16;
  localparam logic [ACC_W-1:0] MAX_LEN = ACC_W'((64'd1 << LEN_BITS) - 1);
  localparam logic [WORD_COUNT_W-1:0] MAX_COUNT = WORD_COUNT_W'((64'd1 << CNT_BITS) - 1);
  localparam int RANDOM_ITEMS = 740;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // One result beat as the bench expects it.
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [BYTE_W-1:0]       data;
    logic                    ws;
    logic                    we;
    logic [REPLY_W-1:0]      reply;
    logic [WORD_COUNT_W-1:0] count;
  } beat_t;

  // A directed row: the byte, and a hand-typed result where it is obvious.
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    beat_t             beat;
  } stim_row_t;

  typedef enum logic [1:0] {PARSE_IDLE, PARSE_PREFIX, PARSE_PAYLOAD} parse_state_t;

  localparam logic [REPLY_W-1:0] REPLY_CODE [4] = '{RT_DONE, RT_RE, RT_TRAP, RT_FATAL};

  localparam stim_row_t DIRECTED [22] = '{
    '{8'h00, 1'b1, '{KIND_END, 8'h00, 1'b0, 1'b0, RT_OTHER, 16'd0}},
    '{8'hFF, 1'b1, '{KIND_BAD, 8'h00, 1'b0, 1'b0, RT_OTHER, 16'd0}},
    '{8'hF0, 1'b1, '{KIND_BAD, 8'h00, 1'b0, 1'b0, RT_OTHER, 16'd0}},
    '{8'h05, 1'b0, '0},
    '{8'h21, 1'b0, '0},
    '{8'h64, 1'b0, '0},
    '{8'h6F, 1'b0, '0},
    '{8'h6E, 1'b0, '0},
    '{8'h65, 1'b0, '0},
    '{8'hF7, 1'b1, '{KIND_BAD, 8'h00, 1'b0, 1'b0, RT_OTHER, 16'd0}},
    '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hE0, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_END, 8'h00, 1'b0, 1'b0, RT_DONE, 16'd3}},
    '{8'h00, 1'b1, '{KIND_END, 8'h00, 1'b0, 1'b0, RT_OTHER, 16'd0}}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [BYTE_W-1:0]       in_rx_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [KIND_W-1:0]       out_kind;
  logic [BYTE_W-1:0]       out_data_byte;
  logic                    out_word_start;
  logic                    out_word_end;
  logic [REPLY_W-1:0]      out_reply_type;
  logic [WORD_COUNT_W-1:0] out_word_count;

  api_sentence_word_deframer_core #(
    .LENGTH_BITS(LEN_BITS),
    .COUNT_BITS (CNT_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_word_start(out_word_start),
    .out_word_end  (out_word_end),
    .out_reply_type(out_reply_type),
    .out_word_count(out_word_count)
  );

  string reply_word [4] = '{"!done", "!re", "!trap", "!fatal"};

  beat_t             expected_beats [$];
  logic [BYTE_W-1:0] word_bytes [$];
  int                failures = 0;
  int                bytes_sent;
  int                ready_hold;
  bit                idle_on;

  // Deframer state as the bench tracks it.
  parse_state_t            parse_state;
  logic [ACC_W-1:0]        len_acc;
  int                      prefix_left;
  logic [ACC_W-1:0]        bytes_left;
  bit                      at_start;
  bit                      first_word;
  logic [3:0]              live;
  int                      match_pos;
  logic [WORD_COUNT_W-1:0] word_total;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fresh sentence: first word not yet seen, every reply word still possible.
  function automatic void start_sentence();
    at_start   = 1'b1;
    first_word = 1'b1;
    live       = 4'hF;
    match_pos  = 0;
    word_total = '0;
  endfunction

  // A complete length prefix either closes the sentence or opens a payload.
  task automatic close_length(output bit has, output beat_t r);
    logic [ACC_W-1:0]   len;
    logic [REPLY_W-1:0] rt;
    int                 k;
    len         = (len_acc > MAX_LEN) ? MAX_LEN : len_acc;
    len_acc     = '0;
    prefix_left = 0;
    has         = 1'b0;
    r           = '0;
    if (len == 0) begin
      rt = RT_OTHER;
      if (!first_word) begin
        for (k = 3; k >= 0; k--) begin
          if (live[k]) rt = REPLY_CODE[k];
        end
      end
      has         = 1'b1;
      r.kind      = KIND_END;
      r.reply     = rt;
      r.count     = word_total;
      parse_state = PARSE_IDLE;
      start_sentence();
    end else begin
      bytes_left  = len;
      at_start    = 1'b1;
      parse_state = PARSE_PAYLOAD;
    end
  endtask

  // Advance the tracked state by one byte and give the result it causes.
  task automatic predict_byte(input logic [BYTE_W-1:0] b, output bit has, output beat_t r);
    bit last;
    int k;
    has = 1'b0;
    r   = '0;
    case (parse_state)
      PARSE_PAYLOAD: begin
        last   = (bytes_left <= 1);
        has    = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.ws   = at_start;
        r.we   = last;
        if (first_word) begin
          for (k = 0; k < 4; k++) begin
            if (match_pos >= reply_word[k].len() || reply_word[k][match_pos] != b) live[k] = 1'b0;
          end
          if (match_pos < 7) match_pos++;
        end
        at_start = 1'b0;
        if (last) begin
          if (first_word) begin
            for (k = 0; k < 4; k++) begin
              if (reply_word[k].len() != match_pos) live[k] = 1'b0;
            end
            first_word = 1'b0;
          end
          if (word_total < MAX_COUNT) word_total++;
          bytes_left  = '0;
          parse_state = PARSE_IDLE;
        end else begin
          bytes_left--;
        end
      end
      PARSE_PREFIX: begin
        len_acc = {len_acc[ACC_W-9:0], b};
        if (prefix_left > 1) prefix_left--;
        else close_length(has, r);
      end
      default: begin
        if (b >= LEAD_BAD) begin
          // A bad lead byte is reported and otherwise dropped.
          has    = 1'b1;
          r.kind = KIND_BAD;
        end else if ((b & LEAD_4B) == LEAD_4B) begin
          len_acc     = ACC_W'(b & 8'h0F);
          prefix_left = 3;
          parse_state = PARSE_PREFIX;
        end else if ((b & LEAD_3B) == LEAD_3B) begin
          len_acc     = ACC_W'(b & 8'h1F);
          prefix_left = 2;
          parse_state = PARSE_PREFIX;
        end else if ((b & LEAD_2B) == LEAD_2B) begin
          len_acc     = ACC_W'(b & 8'h3F);
          prefix_left = 1;
          parse_state = PARSE_PREFIX;
        end else begin
          len_acc = ACC_W'(b);
          close_length(has, r);
        end
      end
    endcase
  endtask

  // Drive one byte after a random gap (while idling is on) and hold it until it is accepted.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input beat_t typed_beat);
    int    gap;
    bit    has;
    beat_t r;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_byte(b, has, r);
    if (typed) expected_beats.push_back(typed_beat);
    else if (has) expected_beats.push_back(r);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send a length in one of the prefix forms wide enough to hold it.
  task automatic send_prefix(input int len);
    int               form;
    logic [ACC_W-1:0] v;
    v = ACC_W'(len);
    if (len < 128) form = $urandom_range(1, 4);
    else if (len < 16384) form = $urandom_range(2, 4);
    else if (len < 2097152) form = $urandom_range(3, 4);
    else form = 4;
    case (form)
      1: send_byte(v[7:0], 1'b0, '0);
      2: begin
        send_byte(LEAD_2B | v[13:8], 1'b0, '0);
        send_byte(v[7:0], 1'b0, '0);
      end
      3: begin
        send_byte(LEAD_3B | v[20:16], 1'b0, '0);
        send_byte(v[15:8], 1'b0, '0);
        send_byte(v[7:0], 1'b0, '0);
      end
      default: begin
        send_byte(LEAD_4B | v[27:24], 1'b0, '0);
        send_byte(v[23:16], 1'b0, '0);
        send_byte(v[15:8], 1'b0, '0);
        send_byte(v[7:0], 1'b0, '0);
      end
    endcase
  endtask

  task automatic send_word();
    int i;
    send_prefix(word_bytes.size());
    for (i = 0; i < word_bytes.size(); i++) send_byte(word_bytes[i], 1'b0, '0);
  endtask

  task automatic send_bad_lead();
    send_byte(8'($urandom_range(240, 255)), 1'b0, '0);
  endtask

  // First word: a reply word exactly, a near miss of one, or random bytes.
  task automatic build_first_word();
    int    pick;
    int    pos;
    string w;
    word_bytes.delete();
    pick = $urandom_range(0, 9);
    w    = reply_word[$urandom_range(0, 3)];
    if (pick >= 8) begin
      repeat ($urandom_range(1, 8)) word_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (pos = 0; pos < w.len(); pos++) word_bytes.push_back(w[pos]);
      case (pick)
        4: void'(word_bytes.pop_back());
        5: word_bytes.push_back(8'($urandom_range(0, 255)));
        6: begin
          pos = $urandom_range(0, w.len() - 1);
          word_bytes[pos] = word_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
        7: word_bytes.push_back(8'h00);
        default: ;
      endcase
    end
  endtask

  // Later words: mostly short, now and then a few hundred bytes.
  task automatic build_plain_word();
    int len;
    word_bytes.delete();
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
    repeat (len) word_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // Result side: check every beat taken, then stall ready for a random spell.
  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: kind 0x%0h", out_kind);
        failures++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("kind", 16'(want.kind), 16'(out_kind));
        compare_field("data_byte", 16'(want.data), 16'(out_data_byte));
        compare_field("word_start", 16'(want.ws), 16'(out_word_start));
        compare_field("word_end", 16'(want.we), 16'(out_word_end));
        compare_field("reply_type", 16'(want.reply), 16'(out_reply_type));
        compare_field("word_count", want.count, out_word_count);
      end
      ready_hold = idle_on ? $urandom_range(0, 16) : 0;
      if (ready_hold != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (ready_hold <= 1) out_ready <= 1'b1;
      if (ready_hold > 0) ready_hold = ready_hold - 1;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int i;
    int n;
    int w;
    int random_stop;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    rst_n      = 1'b0;
    idle_on    = 1'b1;
    bytes_sent = 0;
    parse_state = PARSE_IDLE;
    len_acc     = '0;
    prefix_left = 0;
    bytes_left  = '0;
    start_sentence();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: empty sentences, bad leads, every prefix form, a match.
    for (i = 0; i < $size(DIRECTED); i++) begin
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].beat);
    end

    // Random sentences with bad leads mixed in, idling on or off per sentence.
    random_stop = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < random_stop) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        send_bad_lead();
      end else begin
        n = $urandom_range(0, 5);
        for (w = 0; w < n; w++) begin
          if ($urandom_range(0, 7) == 0) send_bad_lead();
          if (w == 0) build_first_word();
          else build_plain_word();
          send_word();
        end
        send_prefix(0);
      end
    end

    // Largest four-byte length: only the start of its payload is sent.
    idle_on <= 1'b1;
    send_byte(8'hEF, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    repeat (20) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/swdf_pkg.sv
src/swdf_matcher.sv
src/api_sentence_word_deframer_core.sv
src/swdf_checker.sv
bench/tb_top.sv
